// ===== sv/stereo_guitar_effect_processor_defines.svh =====
// Assertion macros for the stereo guitar effect processor.
// Included by the RTL files that carry concurrent assertions.
`ifndef STEREO_GUITAR_EFFECT_PROCESSOR_DEFINES_SVH
`define STEREO_GUITAR_EFFECT_PROCESSOR_DEFINES_SVH
`ifndef SYNTH
`define SGE_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define SGE_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SGE_ASSERT_IMP(lbl, a, c)
`define SGE_ASSERT_NXT(lbl, a, c)
`endif
`endif

// ===== sv/sge_pkg.sv =====
// Types and constants shared by the stereo guitar effect processor.
// No dependencies.
package sge_pkg;
  typedef struct packed {
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
  } in_item_t;
  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
  } out_item_t;
  localparam logic [2:0] MODE_COMB2  = 3'd0;
  localparam logic [2:0] MODE_BYPASS = 3'd1;
  localparam logic [2:0] MODE_COMB1  = 3'd2;
  localparam logic [2:0] MODE_RING   = 3'd3;
  localparam logic [2:0] MODE_WAH    = 3'd4;
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_RING = 3'd1;
  localparam logic [2:0] REG_LOW  = 3'd2;
  localparam logic [2:0] REG_HIGH = 3'd3;
  localparam logic [2:0] REG_STEP = 3'd4;
  localparam logic [2:0] REG_DAMP = 3'd5;
  localparam int SIN_A = 25736;
  localparam int SIN_B = 10512;
  localparam int SIN_C = 1160;
  localparam int OUT_LIMIT = 32766;
  // Shift-add multiplier request
  typedef struct packed {
    logic              start;
    logic signed [47:0] a;
    logic [16:0]       b;
    logic              neg;
  } mul_req_t;
  typedef struct packed {
    logic              done;
    logic signed [63:0] p;
  } mul_rsp_t;
endpackage

// ===== sv/stereo_guitar_effect_processor.sv =====
// Stereo guitar effect processor: comb, bypass, ring modulator and auto-wah.
// Comb, bypass and unused modes register the result with the input transfer and
// show it in the next cycle; ring takes 6 serial multiplies and wah takes 10.
// One pair in flight; next input taken the cycle after the result transfer.
// Synchronous active-low reset restores register defaults, clears delay lines, carrier
// and filter state, and restarts the sweep at its start value.
// Depends on sge_pkg, sge_serial_mul and the defines header.
`include "stereo_guitar_effect_processor_defines.svh"
module stereo_guitar_effect_processor #(
  parameter int HISTORY_DEPTH = 11,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sge_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sge_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import sge_pkg::*;
  localparam int TW = $clog2(SINE_TABLE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE, S_SIN_X2, S_SIN_T1, S_SIN_T2, S_SIN_Y, S_RING_L, S_RING_R,
    S_QB, S_BAND, S_LOW, S_OUT
  } state_t;

  state_t state_r;
  logic [2:0] mode_r;
  logic [15:0] step_r, phase_r;
  logic [23:0] low_r, high_r, sweep_r;
  logic [15:0] sstep_r;
  logic [14:0] damp_r;
  logic falling_r;
  logic signed [15:0] hl_r [HISTORY_DEPTH];
  logic signed [15:0] hr_r [HISTORY_DEPTH];
  logic signed [31:0] lo_r [2];
  logic signed [31:0] bd_r [2];
  logic signed [31:0] hi_r;
  logic ch_r;
  logic signed [15:0] xl_r, xr_r;
  logic [15:0] ang_r;
  logic [14:0] sx_r;
  logic [31:0] sx2_r, st_r;
  logic signed [17:0] sine_r;
  logic signed [15:0] yl_r, yr_r;
  logic out_valid_r;
  logic wait_r;
  mul_req_t req;
  mul_rsp_t rsp;

  sge_serial_mul u_mul (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  function automatic logic signed [15:0] clamp16(input logic signed [63:0] v);
    if (v > 64'(OUT_LIMIT)) return 16'(OUT_LIMIT);
    if (v < -64'(OUT_LIMIT)) return -16'(OUT_LIMIT);
    return v[15:0];
  endfunction
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction
  // truncating divide by 2^k toward zero
  function automatic logic signed [63:0] tdiv(input logic signed [63:0] v, input int k);
    logic signed [63:0] b;
    b = v + ((v < 0) ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0);
    return b >>> k;
  endfunction

  logic [15:0] tbl_ang;
  logic [TW-1:0] tidx;
  logic [23:0] sweep_nxt;
  logic falling_nxt;
  logic signed [63:0] cmb_l, cmb_r;

  // quantise angle to table entry
  assign tidx = TW'((32'(ang_r) * SINE_TABLE_DEPTH) >> 16);
  assign tbl_ang = 16'((32'(tidx) << 16) / SINE_TABLE_DEPTH);

  // sweep update
  always_comb begin
    sweep_nxt = sweep_r; falling_nxt = falling_r;
    if (!falling_r) begin
      if (sweep_r < high_r)
        sweep_nxt = (25'(sweep_r) + 25'(sstep_r) > 25'hFFFFFF) ? 24'hFFFFFF
                    : sweep_r + 24'(sstep_r);
      else falling_nxt = 1'b1;
    end else begin
      if (sweep_r > low_r)
        sweep_nxt = (sweep_r > 24'(sstep_r)) ? sweep_r - 24'(sstep_r) : '0;
      else falling_nxt = 1'b0;
    end
  end

  assign cmb_l = tdiv(64'(in_data.left_in) * 4 +
      ((mode_r == MODE_COMB2) ? 64'(hl_r[5]) * 2 : 64'sd0) + 64'(hl_r[10]), 3);
  assign cmb_r = tdiv(64'(in_data.right_in) * 4 +
      ((mode_r == MODE_COMB2) ? 64'(hr_r[5]) * 2 : 64'sd0) + 64'(hr_r[10]), 3);

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data.left_out = yl_r;
  assign out_data.right_out = yr_r;

  logic signed [31:0] xc, bcur, lcur;
  assign xc = ch_r ? 32'(xr_r) : 32'(xl_r);
  assign bcur = bd_r[ch_r];
  assign lcur = lo_r[ch_r];

  logic [14:0] qx;
  logic [31:0] yv;
  always_comb begin
    qx = tbl_ang[14] ? 15'(16384 - int'(tbl_ang[13:0])) : 15'(tbl_ang[13:0]);
    yv = 32'(rsp.p >>> 13);
  end

  // multiplier request per state, issued on entry
  always_comb begin
    req = '0;
    if (!wait_r) begin
      req.start = (state_r != S_IDLE) && (state_r != S_OUT);
      case (state_r)
        S_SIN_X2: begin req.a = 48'(qx); req.b = 17'(qx); end
        S_SIN_T1: begin req.a = 48'(sx2_r); req.b = 17'(SIN_C); end
        S_SIN_T2: begin req.a = 48'(sx2_r); req.b = 17'(st_r); end
        S_SIN_Y:  begin req.a = 48'(sx_r); req.b = 17'(st_r); end
        S_RING_L: begin req.a = 48'(xl_r); req.b = 17'(sine_r < 0 ? -sine_r : sine_r);
                        req.neg = sine_r < 0; end
        S_RING_R: begin req.a = 48'(xr_r); req.b = 17'(sine_r < 0 ? -sine_r : sine_r);
                        req.neg = sine_r < 0; end
        S_QB:     begin req.a = 48'(bcur); req.b = 17'(damp_r); end
        S_BAND:   begin req.a = 48'(hi_r); req.b = 17'(sine_r); end
        S_LOW:    begin req.a = 48'(bcur); req.b = 17'(sine_r); end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; wait_r <= 1'b0; out_valid_r <= 1'b0;
      mode_r <= MODE_WAH; step_r <= 16'd655; low_r <= 24'd152170;
      high_r <= 24'd1521700; sstep_r <= 16'd104; damp_r <= 15'd22938;
      phase_r <= '0; sweep_r <= 24'd190212; falling_r <= 1'b0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin hl_r[k] <= '0; hr_r[k] <= '0; end
      for (int k = 0; k < 2; k++) begin lo_r[k] <= '0; bd_r[k] <= '0; end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_MODE: mode_r <= cfg_data[2:0];
          REG_RING: step_r <= cfg_data[15:0];
          REG_LOW:  low_r <= cfg_data;
          REG_HIGH: high_r <= cfg_data;
          REG_STEP: sstep_r <= cfg_data[15:0];
          REG_DAMP: damp_r <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (req.start) wait_r <= 1'b1;
      case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          xl_r <= in_data.left_in; xr_r <= in_data.right_in; ch_r <= 1'b0;
          case (mode_r)
            MODE_COMB2, MODE_COMB1: begin
              yl_r <= clamp16(cmb_l); yr_r <= clamp16(cmb_r); out_valid_r <= 1'b1;
              for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
                hl_r[k] <= hl_r[k-1]; hr_r[k] <= hr_r[k-1];
              end
              hl_r[0] <= in_data.left_in; hr_r[0] <= in_data.right_in;
            end
            MODE_BYPASS: begin
              yl_r <= in_data.left_in; yr_r <= in_data.right_in; out_valid_r <= 1'b1;
            end
            MODE_RING: begin ang_r <= phase_r; state_r <= S_SIN_X2; end
            MODE_WAH: begin
              sweep_r <= sweep_nxt; falling_r <= falling_nxt;
              ang_r <= sweep_nxt[23:8] >> 1; state_r <= S_SIN_X2;
            end
            default: begin yl_r <= '0; yr_r <= '0; out_valid_r <= 1'b1; end
          endcase
        end
        S_SIN_X2: if (!wait_r) sx_r <= qx;
          else if (rsp.done) begin
            wait_r <= 1'b0; sx2_r <= 32'(rsp.p >>> 14); state_r <= S_SIN_T1;
          end
        S_SIN_T1: if (rsp.done && wait_r) begin
          wait_r <= 1'b0; st_r <= 32'(SIN_B) - 32'(rsp.p >>> 14); state_r <= S_SIN_T2;
        end
        S_SIN_T2: if (rsp.done && wait_r) begin
          wait_r <= 1'b0; st_r <= 32'(SIN_A) - 32'(rsp.p >>> 14); state_r <= S_SIN_Y;
        end
        S_SIN_Y: if (rsp.done && wait_r) begin
          wait_r <= 1'b0;
          if (mode_r == MODE_RING) begin
            sine_r <= tbl_ang[15] ? -18'((yv > 32767) ? 32767 : yv)
                                  : 18'((yv > 32767) ? 32767 : yv);
            state_r <= S_RING_L;
          end else begin
            sine_r <= tbl_ang[15] ? -18'(2 * ((yv > 32767) ? 32767 : yv))
                                  : 18'(2 * ((yv > 32767) ? 32767 : yv));
            state_r <= S_QB;
          end
        end
        S_RING_L: if (rsp.done && wait_r) begin
          wait_r <= 1'b0; yl_r <= clamp16(tdiv(rsp.p, 15)); state_r <= S_RING_R;
        end
        S_RING_R: if (rsp.done && wait_r) begin
          wait_r <= 1'b0; yr_r <= clamp16(tdiv(rsp.p, 15));
          phase_r <= phase_r + step_r; state_r <= S_OUT;
        end
        S_QB: if (rsp.done && wait_r) begin
          wait_r <= 1'b0;
          hi_r <= sat32(64'(xc) - 64'(lcur) - tdiv(rsp.p, 14)); state_r <= S_BAND;
        end
        S_BAND: if (rsp.done && wait_r) begin
          wait_r <= 1'b0; bd_r[ch_r] <= sat32(tdiv(rsp.p, 15) + 64'(bcur));
          state_r <= S_LOW;
        end
        S_LOW: if (rsp.done && wait_r) begin
          wait_r <= 1'b0; lo_r[ch_r] <= sat32(tdiv(rsp.p, 15) + 64'(lcur));
          if (ch_r) yr_r <= clamp16(64'(bcur)); else yl_r <= clamp16(64'(bcur));
          ch_r <= ~ch_r; state_r <= ch_r ? S_OUT : S_QB;
        end
        S_OUT: begin out_valid_r <= 1'b1; state_r <= S_IDLE; end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SGE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `SGE_ASSERT_IMP(a_busy_no_accept, state_r != S_IDLE, !in_ready)
  `SGE_ASSERT_IMP(a_wait_only_busy, wait_r, state_r != S_IDLE && state_r != S_OUT)
endmodule

// ===== sv/sge_serial_mul.sv =====
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
// Depends on sge_pkg.
module sge_serial_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  sge_pkg::mul_req_t req,
  output sge_pkg::mul_rsp_t rsp
);
  import sge_pkg::*;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [63:0] mcand_r, mcand_nxt;
  logic [16:0] mplier_r, mplier_nxt;
  logic neg_r, neg_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;

  // one partial product a cycle, magnitude of b, sign applied at the end
  always_comb begin
    acc_nxt = acc_r; mcand_nxt = mcand_r; mplier_nxt = mplier_r;
    neg_nxt = neg_r; cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt = '0; mcand_nxt = 64'(req.a); mplier_nxt = req.b;
      neg_nxt = req.neg; cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt = mcand_r <<< 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd16) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
        if (neg_r) acc_nxt = -(mplier_r[0] ? acc_r + mcand_r : acc_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt; mcand_r <= mcand_nxt; mplier_r <= mplier_nxt; neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.p = acc_r;
endmodule

// ===== tb/stereo_guitar_effect_processor_checker.sv =====
// Checker for the stereo guitar effect processor: watches the three channels,
// predicts each processed pair and compares it with what the block returns.
// Depends on sge_pkg.
module stereo_guitar_effect_processor_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  sge_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  sge_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sge_pkg::*;

  localparam int  TABLE_DEPTH = 1024;
  localparam int  NEAR_TAP = 5;
  localparam int  FAR_TAP = 10;
  localparam longint FREQ_TOP = 64'hFFFFFF;

  // register copies
  logic [2:0]  fx_mode;
  logic [15:0] ring_step;
  logic [23:0] low_bound, high_bound;
  logic [15:0] sweep_step;
  logic [14:0] damping;

  // block state copies
  int          hist_l[11], hist_r[11];
  logic [15:0] carrier;
  longint      sweep;
  bit          falling;
  longint      lp_l, bp_l, lp_r, bp_r;

  out_item_t   pairs_due[$];

  // quarter-wave polynomial sine, Q1.15
  function automatic longint poly_sine(logic [15:0] u);
    longint unsigned x, x2, t, y;
    x = u[14] ? 64'(16384 - u[13:0]) : 64'(u[13:0]);
    x2 = (x * x) >> 14;
    t = SIN_B - ((x2 * SIN_C) >> 14);
    t = SIN_A - ((x2 * t) >> 14);
    y = (x * t) >> 13;
    if (y > 32767) y = 32767;
    return u[15] ? -longint'(y) : longint'(y);
  endfunction

  function automatic longint table_sine(logic [15:0] u);
    longint unsigned idx;
    idx = (64'(u) * TABLE_DEPTH) >> 16;
    return poly_sine(16'((idx << 16) / TABLE_DEPTH));
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > OUT_LIMIT) v = OUT_LIMIT;
    if (v < -OUT_LIMIT) v = -OUT_LIMIT;
    return v[15:0];
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // one state-variable filter step, returns the band output
  function automatic longint svf_step(ref longint lp, ref longint bp, input longint x,
                                      input longint f1);
    longint qb, hp;
    qb = (longint'(damping) * bp) / 16384;
    hp = sat32(x - lp - qb);
    bp = sat32((f1 * hp) / 32768 + bp);
    lp = sat32((f1 * bp) / 32768 + lp);
    return bp;
  endfunction

  function automatic void push_history(ref int h[11], input int x);
    for (int k = 10; k >= 1; k--) h[k] = h[k-1];
    h[0] = x;
  endfunction

  // predicted output for one stereo pair, advancing the state copies
  function automatic out_item_t process_pair(in_item_t s);
    out_item_t r;
    longint xl, xr, sn, f1;
    xl = s.left_in;
    xr = s.right_in;
    r = '0;
    case (fx_mode)
      MODE_COMB2: begin
        r.left_out  = clamp16((4*xl + 2*hist_l[NEAR_TAP] + hist_l[FAR_TAP]) / 8);
        r.right_out = clamp16((4*xr + 2*hist_r[NEAR_TAP] + hist_r[FAR_TAP]) / 8);
        push_history(hist_l, int'(xl));
        push_history(hist_r, int'(xr));
      end
      MODE_BYPASS: r = {s.left_in, s.right_in};
      MODE_COMB1: begin
        r.left_out  = clamp16((4*xl + hist_l[FAR_TAP]) / 8);
        r.right_out = clamp16((4*xr + hist_r[FAR_TAP]) / 8);
        push_history(hist_l, int'(xl));
        push_history(hist_r, int'(xr));
      end
      MODE_RING: begin
        sn = table_sine(carrier);
        r.left_out  = clamp16((xl * sn) / 32768);
        r.right_out = clamp16((xr * sn) / 32768);
        carrier = carrier + ring_step;
      end
      MODE_WAH: begin
        // triangle sweep first, then the filters
        if (!falling) begin
          if (sweep < high_bound) begin
            sweep = sweep + sweep_step;
            if (sweep > FREQ_TOP) sweep = FREQ_TOP;
          end else falling = 1;
        end else begin
          if (sweep > low_bound) sweep = (sweep > sweep_step) ? sweep - sweep_step : 0;
          else falling = 0;
        end
        f1 = 2 * table_sine(16'(sweep >> 9));
        r.left_out  = clamp16(svf_step(lp_l, bp_l, xl, f1));
        r.right_out = clamp16(svf_step(lp_r, bp_r, xr, f1));
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      fx_mode = MODE_WAH;
      ring_step = 655;
      low_bound = 152170;
      high_bound = 1521700;
      sweep_step = 104;
      damping = 22938;
      foreach (hist_l[k]) begin
        hist_l[k] = 0;
        hist_r[k] = 0;
      end
      carrier = 0;
      sweep = 190212;
      falling = 0;
      lp_l = 0; bp_l = 0; lp_r = 0; bp_r = 0;
      pairs_due.delete();
      pending <= 0;
    end else begin
      // input transfer sees the settings from before this edge
      if (in_valid && in_ready) pairs_due.push_back(process_pair(in_data));
      // register write transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE: fx_mode = cfg_data[2:0];
          REG_RING: ring_step = cfg_data[15:0];
          REG_LOW:  low_bound = cfg_data;
          REG_HIGH: high_bound = cfg_data;
          REG_STEP: sweep_step = cfg_data[15:0];
          REG_DAMP: damping = cfg_data[14:0];
          default: ;
        endcase
      end
      // result transfer
      if (out_valid && out_ready) begin
        if (pairs_due.size() == 0) begin
          $display("[%0t] unexpected result pair %0d %0d", $time,
                   out_data.left_out, out_data.right_out);
          errors++;
        end else begin
          want = pairs_due.pop_front();
          if (out_data.left_out !== want.left_out)
            report("left_out", out_data.left_out, want.left_out);
          if (out_data.right_out !== want.right_out)
            report("right_out", out_data.right_out, want.right_out);
        end
      end
      pending <= pairs_due.size();
    end
  end

  initial errors = 0;
endmodule

// ===== tb/stereo_guitar_effect_processor_tb.sv =====
// Testbench top for the stereo guitar effect processor: clock, reset, stimulus
// and verdict. Depends on sge_pkg, the block and its checker module.
module stereo_guitar_effect_processor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sge_pkg::*;

  localparam int SETTLE = 400;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready;
  in_item_t in_data = '0;
  logic out_valid, out_ready = 0;
  out_item_t out_data;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = REG_MODE;
  logic [23:0] cfg_data = '0;
  int errors, pending;
  int cycles = 0;
  int burst_left = 4;
  bit valid_on = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  stereo_guitar_effect_processor dut (.*);

  stereo_guitar_effect_processor_checker chk (.*);

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("stereo_guitar_effect_processor regression: fail");
      $finish;
    end
  end

  // receiver stalls: randomly chosen stretches of free flow, random and long stalls
  int stall_len = 0, stall_kind = 0;
  always @(posedge clk) begin
    if (stall_len == 0) begin
      stall_len <= $urandom_range(5, 60);
      stall_kind <= $urandom_range(0, 2);
    end else stall_len <= stall_len - 1;
    case (stall_kind)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // one pair transfer, in bursts with gaps between them
  task automatic send_pair(logic [15:0] l, logic [15:0] r);
    in_data <= {l, r};
    in_valid <= 1'b1;
    valid_on = 1;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      valid_on = 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
  endtask

  // let every pending pair come back, then wait out any work in progress
  task automatic drain();
    if (valid_on) begin
      in_valid <= 1'b0;
      valid_on = 0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] rand_freq();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'd8388608;
      2: return 24'hffffff;
      default: return 24'($urandom_range(0, 8388608));
    endcase
  endfunction

  initial begin
    logic [2:0] m;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: wah at reset settings, with extremes
    send_pair(16'h7fff, 16'h8000);
    send_pair(16'h8000, 16'h7fff);
    send_pair(16'h0000, 16'hffff);
    drain();
    // bypass
    write_reg(REG_MODE, MODE_BYPASS);
    send_pair(16'h8000, 16'h7fff);
    send_pair(16'h5555, 16'haaaa);
    drain();
    // two-tap comb: fill the delay line so both taps are reached
    write_reg(REG_MODE, MODE_COMB2);
    for (int k = 0; k < 12; k++)
      send_pair(k[0] ? 16'h7fff : 16'h8000, k[1] ? 16'h8000 : 16'h7fff);
    drain();
    // one-tap comb, ring, unused modes
    write_reg(REG_MODE, MODE_COMB1);
    send_pair(16'h7fff, 16'h8000);
    send_pair(16'hffff, 16'h0001);
    drain();
    write_reg(REG_RING, 24'd16384);
    write_reg(REG_MODE, MODE_RING);
    for (int k = 0; k < 4; k++) send_pair(16'h8000, 16'h7fff);
    drain();
    write_reg(REG_MODE, 3'd5);
    send_pair(16'h1234, 16'h8000);
    drain();
    write_reg(REG_MODE, 3'd7);
    send_pair(16'h7fff, 16'hffff);
    drain();
    // index past the last register is ignored
    write_reg(3'd6, 24'hffffff);

    // random phases with random settings, extremes included
    for (int ph = 0; ph < 16; ph++) begin
      m = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      if (ph < 5) m = MODE_WAH;
      write_reg(REG_MODE, m);
      write_reg(REG_RING, $urandom_range(0, 3) == 0 ? 24'd32768 : 24'($urandom_range(0, 32768)));
      write_reg(REG_LOW, rand_freq());
      write_reg(REG_HIGH, rand_freq());
      write_reg(REG_STEP, $urandom_range(0, 3) == 0 ? 24'd65535 : 24'($urandom_range(0, 65535)));
      write_reg(REG_DAMP, $urandom_range(0, 3) == 0 ? 24'($urandom_range(0, 1) * 32767)
                                                     : 24'($urandom_range(0, 32767)));
      repeat ($urandom_range(25, 50)) send_pair(rand_sample(), rand_sample());
      drain();
    end

    if (errors == 0)
      $display("stereo_guitar_effect_processor regression: pass");
    else
      $display("stereo_guitar_effect_processor regression: fail");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/sge_pkg.sv
sv/sge_serial_mul.sv
sv/stereo_guitar_effect_processor.sv
tb/stereo_guitar_effect_processor_checker.sv
tb/stereo_guitar_effect_processor_tb.sv
